FILE: hdl/shw_pkg.sv
`timescale 1ns / 1ps
package shw_pkg;

  typedef enum logic [1:0] {
    ACT_ENTER  = 2'd0,
    ACT_LEAVE  = 2'd1,
    ACT_FOLD   = 2'd2,
    ACT_RESUME = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_ERROR = 2'd1,
    CAUSE_TIME  = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_WINDOW = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_FRAMES = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAMP,
    ST_FOLD,
    ST_DONE
  } state_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AvgW     = 40;
  localparam int unsigned OverW    = 10;
  localparam logic [OverW-1:0] OverMax = '1;
  localparam logic [15:0] WindowReset = 16'd300;
  localparam logic [31:0] LimitReset  = 32'd40000;
  localparam logic [9:0]  FramesReset = 10'd120;

  // one queued item between front and back
  typedef struct packed {
    action_e     action;
    logic [2:0]  client_id;
    logic        is_unload;
    logic [31:0] elapsed_ticks;
    logic        has_error;
    logic [31:0] frame_number;
    logic        measured;
  } item_t;

  typedef struct packed {
    logic        allowed;
    logic [7:0]  newly_suspended;
    cause_e      cause;
    logic [7:0]  suspended_mask;
  } result_t;

endpackage

FILE: hdl/shw_front.sv
`timescale 1ns / 1ps
// input side: accepts items into a two-entry queue
module shw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  shw_pkg::item_t  item_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output shw_pkg::item_t  q_item_o
);
  import shw_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o   = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];
  assign push      = valid_i && ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/shw_back.sv
`timescale 1ns / 1ps
// execution side: per-client state, error ring memory, fold sweep
module shw_back #(
  parameter int unsigned CLIENTS     = 8,
  parameter int unsigned ERROR_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  shw_pkg::item_t   q_item_i,
  input  logic [7:0]       client_enable_i,
  input  logic [15:0]      window_i,
  input  logic [31:0]      limit_i,
  input  logic [9:0]       frames_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output shw_pkg::result_t res_o
);
  import shw_pkg::*;

  localparam int unsigned CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned SW = $clog2(ERROR_SLOTS);
  localparam int unsigned FW = $clog2(ERROR_SLOTS + 1);
  localparam int unsigned MD = CLIENTS * ERROR_SLOTS;
  localparam int unsigned MW = $clog2(MD);
  localparam logic [FW-1:0] Full = FW'(ERROR_SLOTS);

  state_e state_q, state_d;
  item_t  it_q;
  logic [CW-1:0] fc_q;

  logic [SW-1:0]   head_q [CLIENTS];
  logic [FW-1:0]   fill_q [CLIENTS];
  logic [CLIENTS-1:0] susp_q;
  logic [OverW-1:0] over_q [CLIENTS];
  logic [AvgW-1:0] avg_q [CLIENTS];
  logic [31:0]     pend_q [CLIENTS];
  logic [31:0]     stamps [MD];
  logic [31:0]     oldest_q;

  logic            res_v_q;
  result_t         res_q;
  logic [7:0]      newly_q;
  cause_e          cause_q;

  logic            id_ok;
  logic [CW-1:0]   id;
  logic [SW-1:0]   nhead;
  logic [FW-1:0]   nfill;
  logic [AvgW-1:0] avg_new;
  logic [AvgW-1:0] lim16;
  logic [OverW-1:0] over_inc;
  logic            fold_ok;
  logic            take;

  assign id    = it_q.client_id[CW-1:0];
  assign id_ok = ({29'd0, it_q.client_id} < 32'(CLIENTS));
  assign take  = q_valid_i && (state_q == ST_IDLE) && !res_v_q;
  assign q_ready_o = take;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;

  assign nhead = (head_q[id] == SW'(ERROR_SLOTS - 1)) ? '0 : head_q[id] + 1'b1;
  assign nfill = (fill_q[id] < Full) ? fill_q[id] + 1'b1 : fill_q[id];
  assign lim16 = {4'd0, limit_i, 4'd0};
  assign fold_ok = it_q.measured && client_enable_i[fc_q] && !susp_q[fc_q];
  assign avg_new = avg_q[fc_q] - (avg_q[fc_q] >> 4) + {8'd0, pend_q[fc_q]};
  assign over_inc = (over_q[fc_q] < OverMax) ? over_q[fc_q] + 1'b1 : over_q[fc_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) begin
        unique case (q_item_i.action)
          ACT_FOLD:  state_d = ST_FOLD;
          ACT_LEAVE: state_d = ST_STAMP;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_STAMP: state_d = ST_DONE;
      ST_FOLD:  if (fc_q == CW'(CLIENTS - 1)) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // error ring memory, read of the slot after head
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STAMP && id_ok && it_q.has_error) begin
      stamps[MW'(id * ERROR_SLOTS + head_q[id])] <= it_q.frame_number;
    end
    oldest_q <= stamps[MW'(id * ERROR_SLOTS + nhead)];
  end

  always_ff @(posedge clk_i) begin
    if (take) it_q <= q_item_i;
  end

  // control and per-client state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fc_q    <= '0;
      susp_q  <= '0;
      res_v_q <= 1'b0;
      newly_q <= '0;
      cause_q <= CAUSE_NONE;
      res_q   <= '0;
      for (int c = 0; c < CLIENTS; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
        over_q[c] <= '0;
        avg_q[c]  <= '0;
        pend_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      if (take) begin
        fc_q    <= '0;
        newly_q <= '0;
        cause_q <= CAUSE_NONE;
      end
      unique case (state_q)
        ST_STAMP: if (id_ok) begin
          pend_q[id] <= (pend_q[id] > ~it_q.elapsed_ticks) ? '1 :
                        pend_q[id] + it_q.elapsed_ticks;
          if (it_q.has_error) begin
            head_q[id] <= nhead;
            fill_q[id] <= nfill;
          end
        end
        ST_FOLD: begin
          pend_q[fc_q] <= '0;
          if (fold_ok) begin
            avg_q[fc_q] <= avg_new;
            if (avg_new <= lim16) begin
              over_q[fc_q] <= '0;
            end else if (over_inc >= frames_i) begin
              over_q[fc_q] <= '0;
              susp_q[fc_q] <= 1'b1;
              newly_q[fc_q] <= 1'b1;
              cause_q <= CAUSE_TIME;
            end else begin
              over_q[fc_q] <= over_inc;
            end
          end
          fc_q <= fc_q + 1'b1;
        end
        ST_DONE: begin
          res_v_q <= 1'b1;
          res_q.allowed <= 1'b0;
          res_q.newly_suspended <= newly_q;
          res_q.cause <= cause_q;
          res_q.suspended_mask <= 8'(susp_q);
          unique case (it_q.action)
            ACT_ENTER: res_q.allowed <= id_ok && client_enable_i[id] &&
                                        (!susp_q[id] || it_q.is_unload);
            ACT_LEAVE: if (id_ok && it_q.has_error && fill_q[id] == Full &&
                           !susp_q[id] &&
                           (it_q.frame_number - oldest_q) <= {16'd0, window_i}) begin
              susp_q[id] <= 1'b1;
              over_q[id] <= '0;
              res_q.newly_suspended <= 8'(1 << id);
              res_q.cause <= CAUSE_ERROR;
              res_q.suspended_mask <= 8'(susp_q | (CLIENTS'(1) << id));
            end
            ACT_RESUME: if (id_ok && susp_q[id]) begin
              res_q.allowed <= 1'b1;
              head_q[id] <= '0;
              fill_q[id] <= '0;
              over_q[id] <= '0;
              avg_q[id]  <= '0;
              pend_q[id] <= '0;
              susp_q[id] <= 1'b0;
              res_q.suspended_mask <= 8'(susp_q & ~(CLIENTS'(1) << id));
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/script_health_watchdog.sv
`timescale 1ns / 1ps
// the back end holds one item at a time: it takes a new item only when idle and
// once the result of the last item has been taken
// a two-entry input queue accepts items while the back end works
// reset: asynchronous active low, clears all client health and loads register defaults
// error stamps are not cleared; a stamp is read only after being written
module script_health_watchdog #(
  parameter int unsigned CLIENTS     = 8,
  parameter int unsigned ERROR_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  action_i,
  input  logic [2:0]  client_id_i,
  input  logic        is_unload_i,
  input  logic [31:0] elapsed_ticks_i,
  input  logic        has_error_i,
  input  logic [31:0] frame_number_i,
  input  logic        measured_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        allowed_o,
  output logic [7:0]  newly_suspended_o,
  output logic [1:0]  cause_o,
  output logic [7:0]  suspended_mask_o
);
  import shw_pkg::*;

  logic [7:0]  enable_q;
  logic [15:0] window_q;
  logic [31:0] limit_q;
  logic [9:0]  frames_q;
  item_t   in_item, q_item;
  logic    q_valid, q_ready;
  result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      window_q <= WindowReset;
      limit_q  <= LimitReset;
      frames_q <= FramesReset;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_ENABLE: enable_q <= cfg_data_i[7:0];
        REG_WINDOW: window_q <= cfg_data_i[15:0];
        REG_LIMIT:  limit_q  <= cfg_data_i;
        REG_FRAMES: frames_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.action        = action_e'(action_i);
    in_item.client_id     = client_id_i;
    in_item.is_unload     = is_unload_i;
    in_item.elapsed_ticks = elapsed_ticks_i;
    in_item.has_error     = has_error_i;
    in_item.frame_number  = frame_number_i;
    in_item.measured      = measured_i;
  end

  shw_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  shw_back #(.CLIENTS(CLIENTS), .ERROR_SLOTS(ERROR_SLOTS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .client_enable_i(enable_q), .window_i(window_q), .limit_i(limit_q),
    .frames_i(frames_q), .res_valid_o(valid_o), .res_ready_i(ready_i), .res_o(res)
  );

  assign allowed_o         = res.allowed;
  assign newly_suspended_o = res.newly_suspended;
  assign cause_o           = res.cause;
  assign suspended_mask_o  = res.suspended_mask;
endmodule

FILE: tb/sv/script_health_watchdog_tb.sv
`timescale 1ns / 1ps
module script_health_watchdog_tb;
  import shw_pkg::*;

  localparam int unsigned NCLIENT  = 8;
  localparam int unsigned NSLOT    = 8;
  localparam int unsigned MAXCYC   = 1000000;
  localparam int unsigned SETTLE   = 16;

  typedef struct {
    logic       allowed;
    logic [7:0] newly;
    cause_e     cause;
    logic [7:0] mask;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [1:0]  action_i = '0;
  logic [2:0]  client_id_i = '0;
  logic        is_unload_i = 1'b0;
  logic [31:0] elapsed_ticks_i = '0;
  logic        has_error_i = 1'b0;
  logic [31:0] frame_number_i = '0;
  logic        measured_i = 1'b0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic        allowed_o;
  logic [7:0]  newly_suspended_o;
  logic [1:0]  cause_o;
  logic [7:0]  suspended_mask_o;

  script_health_watchdog u_top (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the watchdog registers and per-client health
  logic [7:0]  enable_mask;
  logic [15:0] window_frames;
  logic [31:0] limit_ticks;
  logic [9:0]  suspend_frames;
  logic [31:0] stamp_ring [NCLIENT][NSLOT];
  logic [2:0]  ring_head [NCLIENT];
  logic [3:0]  ring_fill [NCLIENT];
  logic        is_suspended [NCLIENT];
  logic [9:0]  over_frames [NCLIENT];
  logic [39:0] avg_cost_x16 [NCLIENT];
  logic [31:0] pending_cost [NCLIENT];

  verdict_t    verdict_q [$];
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned error_suspends = 0;
  int unsigned time_suspends = 0;
  int unsigned resumes_granted = 0;
  int          burst_left = 0;
  logic [31:0] frame_now;

  task automatic clear_client(int c);
    ring_head[c] = '0;
    ring_fill[c] = '0;
    is_suspended[c] = 1'b0;
    over_frames[c] = '0;
    avg_cost_x16[c] = '0;
    pending_cost[c] = '0;
  endtask

  // expected outcome of one item, updating the shadow health state
  task automatic watchdog_outcome(input item_t it, output verdict_t v);
    int c;
    logic [39:0] lim16;
    logic [32:0] sum;
    logic [2:0]  h;
    v.allowed = 1'b0;
    v.newly = '0;
    v.cause = CAUSE_NONE;
    c = it.client_id;
    case (it.action)
      ACT_ENTER: begin
        v.allowed = enable_mask[c] && (!is_suspended[c] || it.is_unload);
      end
      ACT_LEAVE: begin
        sum = {1'b0, pending_cost[c]} + {1'b0, it.elapsed_ticks};
        pending_cost[c] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (it.has_error) begin
          h = ring_head[c];
          stamp_ring[c][h] = it.frame_number;
          h = h + 3'd1;
          ring_head[c] = h;
          if (ring_fill[c] < NSLOT) ring_fill[c] = ring_fill[c] + 4'd1;
          if (ring_fill[c] == NSLOT && !is_suspended[c] &&
              (it.frame_number - stamp_ring[c][h]) <= {16'd0, window_frames}) begin
            is_suspended[c] = 1'b1;
            over_frames[c] = '0;
            v.newly[c] = 1'b1;
            v.cause = CAUSE_ERROR;
          end
        end
      end
      ACT_FOLD: begin
        lim16 = {4'd0, limit_ticks, 4'd0};
        for (int k = 0; k < NCLIENT; k++) begin
          if (!it.measured || !enable_mask[k] || is_suspended[k]) begin
            pending_cost[k] = '0;
          end else begin
            avg_cost_x16[k] = avg_cost_x16[k] - (avg_cost_x16[k] >> 4)
                              + {8'd0, pending_cost[k]};
            pending_cost[k] = '0;
            if (avg_cost_x16[k] <= lim16) begin
              over_frames[k] = '0;
            end else begin
              if (over_frames[k] != 10'h3FF) over_frames[k] = over_frames[k] + 10'd1;
              if (over_frames[k] >= suspend_frames) begin
                is_suspended[k] = 1'b1;
                over_frames[k] = '0;
                v.newly[k] = 1'b1;
                v.cause = CAUSE_TIME;
              end
            end
          end
        end
      end
      default: begin
        if (is_suspended[c]) begin
          clear_client(c);
          v.allowed = 1'b1;
        end
      end
    endcase
    for (int k = 0; k < NCLIENT; k++) v.mask[k] = is_suspended[k];
  endtask

  // result checker
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && valid_o && ready_i) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycle_cnt);
      end else begin
        e = verdict_q.pop_front();
        if (allowed_o !== e.allowed || newly_suspended_o !== e.newly ||
            cause_o !== e.cause || suspended_mask_o !== e.mask) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: exp allowed=%0b newly=%h cause=%0d mask=%h, ",
                      "got allowed=%0b newly=%h cause=%0d mask=%h"},
                     cycle_cnt, e.allowed, e.newly, e.cause, e.mask,
                     allowed_o, newly_suspended_o, cause_o, suspended_mask_o);
        end
      end
    end
  end

  // receiver stalls: four ready patterns in turn, switched on the cycle counter
  always @(posedge clk_i) begin
    case ((cycle_cnt / 300) % 4)
      0: ready_i <= 1'b1;
      1: ready_i <= ($urandom_range(0, 1) == 0);
      2: ready_i <= (cycle_cnt % 7) < 2;
      default: ready_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAXCYC) begin
      $display("script_health_watchdog_tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(input item_t it);
    verdict_t v;
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    valid_i         <= 1'b1;
    action_i        <= it.action;
    client_id_i     <= it.client_id;
    is_unload_i     <= it.is_unload;
    elapsed_ticks_i <= it.elapsed_ticks;
    has_error_i     <= it.has_error;
    frame_number_i  <= it.frame_number;
    measured_i      <= it.measured;
    do @(posedge clk_i); while (!ready_o);
    watchdog_outcome(it, v);
    verdict_q.push_back(v);
    if (v.cause == CAUSE_ERROR) error_suspends++;
    if (v.cause == CAUSE_TIME) time_suspends += $countones(v.newly);
    if (it.action == ACT_RESUME && v.allowed) resumes_granted++;
    items_sent++;
    burst_left--;
  endtask

  task automatic send(action_e a, int c, bit unl, logic [31:0] el, bit err,
                      logic [31:0] fr, bit meas);
    item_t it;
    it.action = a;
    it.client_id = c[2:0];
    it.is_unload = unl;
    it.elapsed_ticks = el;
    it.has_error = err;
    it.frame_number = fr;
    it.measured = meas;
    send_item(it);
  endtask

  // sender pauses until every outstanding result has arrived
  task automatic drain();
    valid_i <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLE: enable_mask = val[7:0];
      REG_WINDOW: window_frames = val[15:0];
      REG_LIMIT:  limit_ticks = val;
      default:    suspend_frames = val[9:0];
    endcase
  endtask

  task automatic configure(logic [7:0] en, logic [15:0] win, logic [31:0] lim,
                           logic [9:0] frames);
    drain();
    cfg_write(REG_ENABLE, {24'd0, en});
    cfg_write(REG_WINDOW, {16'd0, win});
    cfg_write(REG_LIMIT, lim);
    cfg_write(REG_FRAMES, {22'd0, frames});
  endtask

  // enter, resume, leave and fold right after reset with default registers, out-of-enable clients
  task automatic test_defaults();
    send(ACT_ENTER, 0, 0, 0, 0, 0, 0);
    send(ACT_RESUME, 3, 0, 0, 0, 0, 0);
    send(ACT_LEAVE, 5, 0, 32'd1000, 0, 32'd10, 0);
    send(ACT_FOLD, 0, 0, 0, 0, 32'd11, 1);
  endtask

  // a full error ring inside the window suspends, across frame wraparound
  task automatic test_error_budget();
    configure(8'hFF, 16'd300, 32'hFFFF_FFFF, 10'd1023);
    for (int i = 0; i < 8; i++)
      send(ACT_LEAVE, 2, 0, 32'd5, 1, 32'hFFFF_FFF0 + i * 40, 0);
    send(ACT_ENTER, 2, 0, 0, 0, 0, 0);
    send(ACT_ENTER, 2, 1, 0, 0, 0, 0);
    // error while already suspended does not suspend again
    send(ACT_LEAVE, 2, 0, 32'hFFFF_FFFF, 1, 32'd300, 0);
    send(ACT_RESUME, 2, 0, 0, 0, 0, 0);
    send(ACT_RESUME, 2, 0, 0, 0, 0, 0);
    // ring spread wider than the window
    for (int i = 0; i < 9; i++)
      send(ACT_LEAVE, 7, 0, 0, 1, i * 100, 0);
  endtask

  // saturating cost, zero limit and zero frames, several clients in one fold
  task automatic test_time_budget();
    configure(8'hA5, 16'hFFFF, 32'd0, 10'd0);
    send(ACT_LEAVE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(ACT_LEAVE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(ACT_LEAVE, 5, 0, 32'd1, 0, 0, 0);
    send(ACT_FOLD, 0, 0, 0, 0, 0, 0);
    send(ACT_LEAVE, 5, 0, 32'd1, 0, 0, 0);
    send(ACT_LEAVE, 7, 0, 32'd2, 0, 0, 0);
    send(ACT_LEAVE, 1, 0, 32'd2, 0, 0, 0);
    send(ACT_FOLD, 0, 0, 0, 0, 0, 1);
    send(ACT_FOLD, 0, 0, 0, 0, 0, 1);
    send(ACT_ENTER, 5, 0, 0, 0, 0, 0);
  endtask

  // random traffic under one register setting
  task automatic test_random_phase(int n, int err_pct);
    item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      it.action = r < 45 ? ACT_LEAVE : r < 70 ? ACT_ENTER : r < 91 ? ACT_FOLD : ACT_RESUME;
      it.client_id = 3'($urandom_range(0, 7));
      it.is_unload = $urandom_range(0, 3) == 0;
      case ($urandom_range(0, 3))
        0: it.elapsed_ticks = $urandom_range(0, 100000);
        1: it.elapsed_ticks = limit_ticks + $urandom_range(0, 4000) - 2000;
        2: it.elapsed_ticks = $urandom;
        default: it.elapsed_ticks = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
      it.has_error = $urandom_range(0, 99) < err_pct;
      frame_now = frame_now + ($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, 4));
      it.frame_number = $urandom_range(0, 29) == 0 ? $urandom : frame_now;
      it.measured = $urandom_range(0, 7) != 0;
      send_item(it);
    end
  endtask

  initial begin
    enable_mask = 8'd0;
    window_frames = WindowReset;
    limit_ticks = LimitReset;
    suspend_frames = FramesReset;
    for (int c = 0; c < NCLIENT; c++) clear_client(c);
    frame_now = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_error_budget();
    test_time_budget();

    configure(8'hFF, 16'd40, 32'd20000, 10'd2);
    test_random_phase(250, 40);
    configure(8'h00, 16'd0, 32'd0, 10'd1);
    test_random_phase(150, 30);
    configure(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023);
    test_random_phase(200, 50);
    configure(8'h5A, 16'd200, 32'd50000, 10'd3);
    test_random_phase(250, 30);
    configure(8'($urandom), 16'($urandom), $urandom, 10'($urandom_range(1, 1023)));
    test_random_phase(200, 35);
    configure(8'hFF, 16'd25, 32'd1000000, 10'd1);
    test_random_phase(250, 45);
    configure(8'hC3, 16'($urandom_range(0, 500)), $urandom_range(0, 200000),
              10'($urandom_range(1, 6)));
    test_random_phase(250, 40);
    drain();

    $display("covered %0d items, %0d results: %0d error suspensions, %0d time suspensions",
             items_sent, results_seen, error_suspends, time_suspends);
    $display("resumes granted %0d, mismatches %0d", resumes_granted, mismatches);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("script_health_watchdog_tb: PASS");
    end else begin
      $display("script_health_watchdog_tb: FAIL");
    end
    $finish;
  end

endmodule
